// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define BLMP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its condition.
`define BLMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Property that must hold at every clock edge.
`define BLMP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/blmp_pkg.sv =====
// ----------------------------------------------------------------------------
// blmp_pkg
// Types, codes and helper functions of the BLE MIDI packet event parser.
// ----------------------------------------------------------------------------
package blmp_pkg;

	// Field widths of the stream payloads.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CHSEL_W  = 5;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned BEND_W   = 16;
	localparam int unsigned EVENT_W  = KIND_W + CHSEL_W + 2 * BYTE_W + BEND_W;

	// Offset that centers the 14-bit pitch bend value on zero.
	localparam logic [BEND_W-1:0] BEND_CENTER = 16'd8192;

	// Upper status nibbles of the channel messages.
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CONTROL  = 4'hB;
	localparam logic [3:0] ST_PROGRAM  = 4'hC;
	localparam logic [3:0] ST_PRESSURE = 4'hD;
	localparam logic [3:0] ST_BEND     = 4'hE;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_WAIT_HEADER = 3'd0,
		PH_CANDIDATE   = 3'd1,
		PH_HELD        = 3'd2,
		PH_DISCARD     = 3'd3,
		PH_FIRST       = 3'd4,
		PH_SECOND      = 3'd5,
		PH_PROGRAM     = 3'd6
	} phase_t;

	// Event kinds on the result stream.
	typedef enum logic [KIND_W-1:0] {
		EV_NOTE_OFF = 3'd0,
		EV_NOTE_ON  = 3'd1,
		EV_CONTROL  = 3'd2,
		EV_PROGRAM  = 3'd3,
		EV_BEND     = 3'd4
	} kind_t;

	// Phase and skip count chosen by a status byte.
	typedef struct packed {
		phase_t     phase;
		logic [1:0] disc;
	} start_t;

	// One parsed event with its strobe.
	typedef struct packed {
		logic                     valid;
		kind_t                    kind;
		logic [CHSEL_W-1:0]       channel;
		logic [BYTE_W-1:0]        first_data;
		logic [BYTE_W-1:0]        second_data;
		logic signed [BEND_W-1:0] bend_value;
	} evt_t;

	// Decide where a message goes once its status byte is known.
	function automatic start_t start_message(input logic [BYTE_W-1:0] s,
			input logic [CHSEL_W-1:0] chsel);
		start_t             r;
		logic [CHSEL_W-1:0] ch;
		ch = {1'b0, s[3:0]} + 5'd1;
		r.phase = PH_DISCARD;
		r.disc = 2'd1;
		if (chsel != '0 && ch != chsel) begin
			r.disc = (s[7:4] == ST_PROGRAM || s[7:4] == ST_PRESSURE) ? 2'd1 : 2'd2;
		end else begin
			case (s[7:4])
				ST_NOTE_OFF, ST_NOTE_ON, ST_CONTROL, ST_BEND: begin
					r.phase = PH_FIRST;
				end
				ST_PROGRAM: begin
					r.phase = PH_PROGRAM;
				end
				default: begin
					r.phase = PH_DISCARD;
				end
			endcase
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/blmp_parser.sv =====
// ----------------------------------------------------------------------------
// blmp_parser
// Parse state of the packet and the event formed by the current byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blmp_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [blmp_pkg::CHSEL_W-1:0]     cfg_wr_data,
	input  logic                             en,
	input  logic [blmp_pkg::BYTE_W-1:0]      byte_in,
	input  logic                             start_in,
	output blmp_pkg::evt_t                   evt
);

	blmp_pkg::phase_t                phase_q, phase_d;
	logic [blmp_pkg::BYTE_W-1:0]     held_q, held_d;
	logic [1:0]                      ts_q, ts_d;
	logic [blmp_pkg::BYTE_W-1:0]     status_q, status_d;
	logic [blmp_pkg::BYTE_W-1:0]     saved_q, saved_d;
	logic [1:0]                      disc_q, disc_d;
	logic [blmp_pkg::CHSEL_W-1:0]    chsel_q;

	blmp_pkg::start_t                st_held;
	blmp_pkg::start_t                st_byte;
	logic                            do_body;
	blmp_pkg::phase_t                body_phase;
	logic [blmp_pkg::BYTE_W-1:0]     body_status;
	logic [1:0]                      body_disc;
	logic [1:0]                      ts_inc;
	logic [1:0]                      disc_dec;
	logic [14:0]                     bend_raw;

	// Channel filter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chsel_q <= '0;
		end else if (cfg_wr_en) begin
			chsel_q <= cfg_wr_data;
		end
	end

	assign st_held = blmp_pkg::start_message(held_q, chsel_q);
	assign st_byte = blmp_pkg::start_message(byte_in, chsel_q);
	assign ts_inc = ts_q + 2'd1;

	// Work out which message phase the current byte is a body byte of.
	// A held byte followed by a plain byte is the status of that message.
	always_comb begin
		do_body = 1'b0;
		body_phase = phase_q;
		body_status = status_q;
		body_disc = disc_q;
		case (phase_q)
			blmp_pkg::PH_WAIT_HEADER, blmp_pkg::PH_CANDIDATE: begin
				do_body = 1'b0;
			end
			blmp_pkg::PH_HELD: begin
				if (!byte_in[7]) begin
					do_body = 1'b1;
					body_phase = st_held.phase;
					body_status = held_q;
					if (st_held.phase == blmp_pkg::PH_DISCARD) begin
						body_disc = st_held.disc;
					end
				end
			end
			default: begin
				do_body = 1'b1;
			end
		endcase
		if (start_in) begin
			do_body = 1'b0;
		end
	end

	assign disc_dec = (body_disc != 2'd0) ? body_disc - 2'd1 : body_disc;

	// Next state.
	always_comb begin
		phase_d = phase_q;
		held_d = held_q;
		ts_d = ts_q;
		status_d = status_q;
		saved_d = saved_q;
		disc_d = disc_q;
		if (start_in) begin
			phase_d = blmp_pkg::PH_CANDIDATE;
			ts_d = 2'd0;
			held_d = '0;
			disc_d = 2'd0;
		end else if (do_body) begin
			status_d = body_status;
			disc_d = body_disc;
			case (body_phase)
				blmp_pkg::PH_DISCARD: begin
					disc_d = disc_dec;
					if (disc_dec == 2'd0) begin
						phase_d = blmp_pkg::PH_CANDIDATE;
						ts_d = 2'd0;
					end else begin
						phase_d = blmp_pkg::PH_DISCARD;
					end
				end
				blmp_pkg::PH_FIRST: begin
					saved_d = byte_in;
					phase_d = blmp_pkg::PH_SECOND;
				end
				blmp_pkg::PH_SECOND, blmp_pkg::PH_PROGRAM: begin
					phase_d = blmp_pkg::PH_CANDIDATE;
					ts_d = 2'd0;
				end
				default: begin
					phase_d = body_phase;
				end
			endcase
		end else begin
			case (phase_q)
				blmp_pkg::PH_CANDIDATE: begin
					if (ts_q >= 2'd2 || !byte_in[7]) begin
						status_d = byte_in;
						phase_d = st_byte.phase;
						if (st_byte.phase == blmp_pkg::PH_DISCARD) begin
							disc_d = st_byte.disc;
						end
					end else begin
						held_d = byte_in;
						phase_d = blmp_pkg::PH_HELD;
					end
				end
				blmp_pkg::PH_HELD: begin
					// Two high bytes in a row: the earlier one was a timestamp.
					ts_d = ts_inc;
					if (ts_inc >= 2'd2) begin
						status_d = byte_in;
						phase_d = st_byte.phase;
						if (st_byte.phase == blmp_pkg::PH_DISCARD) begin
							disc_d = st_byte.disc;
						end
					end else begin
						held_d = byte_in;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	assign bend_raw = {byte_in, 7'd0} | {7'd0, saved_q};

	// Event formed by the last data byte of a message.
	always_comb begin
		evt.valid = 1'b0;
		evt.kind = blmp_pkg::EV_BEND;
		evt.channel = {1'b0, body_status[3:0]} + 5'd1;
		evt.first_data = '0;
		evt.second_data = '0;
		evt.bend_value = '0;
		if (do_body) begin
			case (body_phase)
				blmp_pkg::PH_SECOND: begin
					evt.valid = 1'b1;
					evt.first_data = saved_q;
					evt.second_data = byte_in;
					case (body_status[7:4])
						blmp_pkg::ST_NOTE_ON: begin
							evt.kind = (byte_in == '0) ? blmp_pkg::EV_NOTE_OFF
								: blmp_pkg::EV_NOTE_ON;
						end
						blmp_pkg::ST_NOTE_OFF: begin
							evt.kind = blmp_pkg::EV_NOTE_OFF;
						end
						blmp_pkg::ST_CONTROL: begin
							evt.kind = blmp_pkg::EV_CONTROL;
						end
						default: begin
							evt.kind = blmp_pkg::EV_BEND;
							evt.first_data = '0;
							evt.second_data = '0;
							evt.bend_value = $signed({1'b0, bend_raw} - blmp_pkg::BEND_CENTER);
						end
					endcase
				end
				blmp_pkg::PH_PROGRAM: begin
					evt.valid = 1'b1;
					evt.kind = blmp_pkg::EV_PROGRAM;
					evt.first_data = byte_in;
				end
				default: begin
					evt.valid = 1'b0;
				end
			endcase
		end
	end

	// State registers, advanced once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= blmp_pkg::PH_WAIT_HEADER;
			held_q <= '0;
			ts_q <= 2'd0;
			status_q <= '0;
			saved_q <= '0;
			disc_q <= 2'd0;
		end else if (en) begin
			phase_q <= phase_d;
			held_q <= held_d;
			ts_q <= ts_d;
			status_q <= status_d;
			saved_q <= saved_d;
			disc_q <= disc_d;
		end
	end

	`BLMP_ASSERT_ALWAYS(a_ts_range, ts_q != 2'd3, "timestamp count out of range")
	`BLMP_ASSERT_IMPL(a_discard_count, phase_q == blmp_pkg::PH_DISCARD, disc_q != 2'd0,
		"discard phase with nothing left to skip")
	`BLMP_ASSERT_NEXT(a_header_restart, en && start_in,
		phase_q == blmp_pkg::PH_CANDIDATE && ts_q == 2'd0,
		"header byte did not restart message parsing")

endmodule

// ===== hw/rtl/ble_midi_packet_event_parser.sv =====
// ----------------------------------------------------------------------------
// ble_midi_packet_event_parser
// Stream front end: input register, parser and registered event output.
// ----------------------------------------------------------------------------
// The block takes one byte of a BLE MIDI packet per transfer, with tuser set
// on the packet header, and returns one 40-bit event transfer for each complete
// note on, note off, control change, program change or pitch bend message.
// It takes one byte every clock cycle while the input does not stall; a byte
// is captured in the input register, and its event is loaded from there into
// the output register when the input register advances. The input only
// stalls while an event is waiting in the full output register and the byte
// in the input register would produce another one. The channel filter
// register is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while no bytes are in flight, the block itself does not enforce it.
`include "assert_macros.svh"

module ble_midi_packet_event_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [blmp_pkg::CHSEL_W-1:0]         cfg_wr_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [blmp_pkg::BYTE_W-1:0]          s_axis_tdata,   // data_byte
	input  logic                                 s_axis_tuser,   // packet_start
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// event_kind[2:0], channel_number[7:3], first_data[15:8],
	// second_data[23:16], bend_value[39:24]
	output logic [blmp_pkg::EVENT_W-1:0]         m_axis_tdata
);

	logic                            valid_s1;
	logic [blmp_pkg::BYTE_W-1:0]     byte_s1;
	logic                            start_s1;
	logic                            out_valid_q;
	logic [blmp_pkg::EVENT_W-1:0]    out_data_q;
	logic                            out_free;
	logic                            adv;
	blmp_pkg::evt_t                  evt;

	// The input register moves on unless its event finds the output full.
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv = valid_s1 && (!evt.valid || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	blmp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.en          (adv),
		.byte_in     (byte_s1),
		.start_in    (start_s1),
		.evt         (evt)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && evt.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && evt.valid) begin
			out_data_q <= {evt.bend_value, evt.second_data, evt.first_data,
				evt.channel, evt.kind};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	`BLMP_ASSERT_NEXT(a_event_loaded, adv && evt.valid, m_axis_tvalid,
		"parsed event did not reach the output register")
	`BLMP_ASSERT_IMPL(a_stall_cause, !s_axis_tready, out_valid_q && !m_axis_tready && evt.valid,
		"input stalled without a blocked event")
	`BLMP_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv,
		valid_s1 && $stable(byte_s1) && $stable(start_s1),
		"stalled byte lost from the input register")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream test of the BLE MIDI packet event parser.
// ----------------------------------------------------------------------------
// A queue of packet bytes feeds a driver that offers them on the input stream
// with random gaps. Every accepted byte runs through a behavioral parser
// that predicts the events, and a monitor compares every event transfer
// field by field with the oldest prediction. The run starts with a short
// directed sequence and then sends random packets, mostly well formed, under
// several channel filter settings. These include accept-all, channel 1,
// channel 16 and values above 16.

module testbench;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int IDLE_PCT     = 17;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_BYTES  = 290;
	localparam int CALM_FROM    = 1100;
	localparam int CALM_TO      = 1450;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_LEN     = 250;
	localparam int PRINT_CAP    = 100;

	// One packet byte as it goes onto the input stream.
	typedef struct packed {
		logic [7:0] value;
		logic       header;
	} packet_byte_t;

	// One MIDI event as it comes off the output stream.
	typedef struct packed {
		blmp_pkg::kind_t    kind;
		logic [4:0]         channel;
		logic [7:0]         first_data;
		logic [7:0]         second_data;
		logic signed [15:0] bend;
	} event_rec_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [blmp_pkg::CHSEL_W-1:0]   cfg_wr_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [blmp_pkg::BYTE_W-1:0]    s_axis_tdata = '0;
	logic                           s_axis_tuser = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [blmp_pkg::EVENT_W-1:0]   m_axis_tdata;

	packet_byte_t pending_bytes[$];
	event_rec_t   expected_events[$];

	// Behavioral parser state.
	logic [4:0]       chan_filter = '0;
	blmp_pkg::phase_t parse_state = blmp_pkg::PH_WAIT_HEADER;
	logic [7:0]       held_value = '0;
	int               stamp_count = 0;
	logic [7:0]       cur_status = '0;
	logic [7:0]       saved_value = '0;
	logic [1:0]       skip_left = '0;

	int  bytes_accepted = 0;
	int  events_checked = 0;
	int  mismatches = 0;
	int  events_by_kind[5];
	int  filter_writes = 0;
	int  cycle_count = 0;
	logic in_fire = 1'b0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	ble_midi_packet_event_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// A mismatch is counted; the first PRINT_CAP mismatches print one line each.
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t ns: MISMATCH %s", $time, msg);
		end
	endtask

	// A new message begins: expect timestamps or a status byte.
	task automatic restart_message();
		parse_state = blmp_pkg::PH_CANDIDATE;
		stamp_count = 0;
	endtask

	// The status byte decides how many bytes follow and what they mean.
	task automatic open_message(input logic [7:0] s);
		logic [4:0] ch;
		ch = {1'b0, s[3:0]} + 5'd1;
		cur_status = s;
		if (chan_filter != 5'd0 && ch != chan_filter) begin
			skip_left = (s[7:4] == blmp_pkg::ST_PROGRAM ||
				s[7:4] == blmp_pkg::ST_PRESSURE) ? 2'd1 : 2'd2;
			parse_state = blmp_pkg::PH_DISCARD;
		end else begin
			case (s[7:4])
				blmp_pkg::ST_NOTE_OFF, blmp_pkg::ST_NOTE_ON,
				blmp_pkg::ST_CONTROL, blmp_pkg::ST_BEND: begin
					parse_state = blmp_pkg::PH_FIRST;
				end
				blmp_pkg::ST_PROGRAM: begin
					parse_state = blmp_pkg::PH_PROGRAM;
				end
				default: begin
					skip_left = 2'd1;
					parse_state = blmp_pkg::PH_DISCARD;
				end
			endcase
		end
	endtask

	// A byte of the message body: skip it, save it, or finish an event.
	task automatic take_body(input logic [7:0] b);
		event_rec_t  ev;
		logic [15:0] raw;
		ev.kind = blmp_pkg::EV_NOTE_OFF;
		ev.channel = {1'b0, cur_status[3:0]} + 5'd1;
		ev.first_data = saved_value;
		ev.second_data = b;
		ev.bend = '0;
		case (parse_state)
			blmp_pkg::PH_DISCARD: begin
				if (skip_left != 2'd0) skip_left--;
				if (skip_left == 2'd0) restart_message();
			end
			blmp_pkg::PH_FIRST: begin
				saved_value = b;
				parse_state = blmp_pkg::PH_SECOND;
			end
			blmp_pkg::PH_SECOND: begin
				restart_message();
				case (cur_status[7:4])
					blmp_pkg::ST_NOTE_ON: begin
						ev.kind = (b == 8'd0) ? blmp_pkg::EV_NOTE_OFF : blmp_pkg::EV_NOTE_ON;
					end
					blmp_pkg::ST_NOTE_OFF: begin
						ev.kind = blmp_pkg::EV_NOTE_OFF;
					end
					blmp_pkg::ST_CONTROL: begin
						ev.kind = blmp_pkg::EV_CONTROL;
					end
					default: begin
						raw = ({8'd0, b} << 7) | {8'd0, saved_value};
						ev.kind = blmp_pkg::EV_BEND;
						ev.first_data = '0;
						ev.second_data = '0;
						ev.bend = raw - blmp_pkg::BEND_CENTER;
					end
				endcase
				expected_events.push_back(ev);
			end
			blmp_pkg::PH_PROGRAM: begin
				restart_message();
				ev.kind = blmp_pkg::EV_PROGRAM;
				ev.first_data = b;
				ev.second_data = '0;
				expected_events.push_back(ev);
			end
			default: begin
			end
		endcase
	endtask

	// Parse one accepted byte, with one byte of lookahead for timestamps.
	task automatic parse_byte(input logic [7:0] b, input logic header);
		if (header) begin
			restart_message();
			held_value = '0;
			skip_left = '0;
		end else begin
			case (parse_state)
				blmp_pkg::PH_WAIT_HEADER: begin
				end
				blmp_pkg::PH_CANDIDATE: begin
					if (stamp_count >= 2 || !b[7]) begin
						open_message(b);
					end else begin
						held_value = b;
						parse_state = blmp_pkg::PH_HELD;
					end
				end
				blmp_pkg::PH_HELD: begin
					if (b[7]) begin
						stamp_count++;
						if (stamp_count >= 2) open_message(b);
						else held_value = b;
					end else begin
						open_message(held_value);
						take_body(b);
					end
				end
				default: begin
					take_body(b);
				end
			endcase
		end
	endtask

	// Input and output transfers, prediction and checking.
	always @(posedge clk) begin
		event_rec_t want;
		event_rec_t got;
		got.kind = blmp_pkg::kind_t'(m_axis_tdata[2:0]);
		got.channel = m_axis_tdata[7:3];
		got.first_data = m_axis_tdata[15:8];
		got.second_data = m_axis_tdata[23:16];
		got.bend = m_axis_tdata[39:24];
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("event with none expected: tdata %h", m_axis_tdata));
			end else begin
				want = expected_events.pop_front();
				if (got.kind != want.kind)
					report_mismatch($sformatf("event %0d kind %0d, expected %0d",
						events_checked, got.kind, want.kind));
				if (got.channel != want.channel)
					report_mismatch($sformatf("event %0d channel %0d, expected %0d",
						events_checked, got.channel, want.channel));
				if (got.first_data != want.first_data)
					report_mismatch($sformatf("event %0d first_data %h, expected %h",
						events_checked, got.first_data, want.first_data));
				if (got.second_data != want.second_data)
					report_mismatch($sformatf("event %0d second_data %h, expected %h",
						events_checked, got.second_data, want.second_data));
				if (got.bend != want.bend)
					report_mismatch($sformatf("event %0d bend_value %0d, expected %0d",
						events_checked, got.bend, want.bend));
				if (want.kind <= blmp_pkg::EV_BEND) events_by_kind[want.kind]++;
			end
			events_checked++;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			parse_byte(s_axis_tdata, s_axis_tuser);
			void'(pending_bytes.pop_front());
			bytes_accepted++;
		end
	end

	// Byte driver: keeps an offered byte until its transfer, idles at random.
	always @(negedge clk) begin
		bit quiet;
		quiet = (bytes_accepted >= CALM_FROM && bytes_accepted < CALM_TO) ? 1'b0 :
			($urandom_range(0, 99) < IDLE_PCT);
		if (!(s_axis_tvalid && !in_fire)) begin
			if (arst_n && pending_bytes.size() > 0 && !quiet) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_bytes[0].value;
				s_axis_tuser <= pending_bytes[0].header;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Event receiver: random back-pressure plus one long hold-off.
	always @(negedge clk) begin
		if (!hold_done && bytes_accepted >= HOLD_AT) begin
			hold_left = HOLD_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (bytes_accepted >= CALM_FROM && bytes_accepted < CALM_TO) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events still expected",
				cycle_count, expected_events.size());
			$display("ble_midi_packet_event_parser test failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] value, input logic header);
		packet_byte_t item;
		item.value = value;
		item.header = header;
		pending_bytes.push_back(item);
	endtask

	// Wait until every byte is taken and every event has come out.
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_filter(input logic [4:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		chan_filter = value;
		filter_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Pick a data byte: mostly 7-bit, now and then any value.
	function automatic logic [7:0] data_value();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	// One random packet: a header, then messages, some broken or noisy.
	task automatic queue_packet(input logic [4:0] filt);
		int         n_msgs;
		int         roll;
		int         n_data;
		logic [3:0] nib;
		logic [3:0] chan;
		logic [7:0] d;
		n_msgs = $urandom_range(1, 5);
		queue_byte(8'($urandom_range(0, 255)), 1'b1);
		for (int m = 0; m < n_msgs; m++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				repeat ($urandom_range(1, 4))
					queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
			end else begin
				if ($urandom_range(0, 9) != 0)
					queue_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
				if ($urandom_range(0, 19) == 0)
					queue_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
				case ($urandom_range(0, 9))
					0: nib = blmp_pkg::ST_NOTE_OFF;
					1, 2: nib = blmp_pkg::ST_NOTE_ON;
					3: nib = blmp_pkg::ST_CONTROL;
					4: nib = blmp_pkg::ST_PROGRAM;
					5: nib = blmp_pkg::ST_BEND;
					6: nib = blmp_pkg::ST_PRESSURE;
					7: nib = 4'($urandom_range(10, 15));
					default: nib = 4'($urandom_range(8, 15));
				endcase
				if (filt >= 5'd1 && filt <= 5'd16 && $urandom_range(0, 1) == 0)
					chan = 4'(filt - 5'd1);
				else
					chan = 4'($urandom_range(0, 15));
				if ($urandom_range(0, 32) == 0) nib[3] = 1'b0;
				queue_byte({nib, chan}, 1'b0);
				n_data = (nib == blmp_pkg::ST_PROGRAM || nib == blmp_pkg::ST_PRESSURE ||
					!nib[3]) ? 1 : 2;
				if ($urandom_range(0, 19) == 0) begin
					// Cut the message off with the next packet header.
					if (n_data == 2) queue_byte(data_value(), 1'b0);
					return;
				end
				for (int i = 0; i < n_data; i++) begin
					d = data_value();
					if (i == 1 && nib == blmp_pkg::ST_NOTE_ON && $urandom_range(0, 9) == 0)
						d = '0;
					queue_byte(d, 1'b0);
				end
			end
		end
	endtask

	// Directed opening: stray bytes, every event kind, edge cases.
	task automatic queue_directed();
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h81, 1'b1);
		queue_byte(8'h81, 1'b0);
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h3C, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h40, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h85, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hB3, 1'b0);
		queue_byte(8'h07, 1'b0);
		queue_byte(8'h64, 1'b0);
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'h05, 1'b0);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		// Two timestamps force the status; full-range bend bytes follow.
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hE1, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		// Status without its high bit skips one byte.
		queue_byte(8'h45, 1'b0);
		queue_byte(8'h11, 1'b0);
		// A note on cut off by a new header.
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h3C, 1'b0);
		queue_byte(8'h00, 1'b1);
	endtask

	// Stimulus: reset, then one phase per filter setting.
	initial begin
		logic [4:0] filters[7];
		int         phase_target;
		filters = '{5'd0, 5'd16, 5'd1, 5'd17, 5'd31, 5'($urandom_range(2, 15)), 5'd0};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int p = 0; p < 7; p++) begin
			wait_idle();
			write_filter(filters[p]);
			@(posedge clk);
			if (p == 0) queue_directed();
			phase_target = bytes_accepted + pending_bytes.size() + PHASE_BYTES;
			while (bytes_accepted + pending_bytes.size() < phase_target) begin
				queue_packet(filters[p]);
				@(posedge clk);
			end
		end
		wait_idle();
		$display("sent %0d bytes under %0d filter settings, checked %0d events",
			bytes_accepted, filter_writes, events_checked);
		$display("events by kind: note off %0d, note on %0d, control %0d, program %0d, bend %0d",
			events_by_kind[blmp_pkg::EV_NOTE_OFF], events_by_kind[blmp_pkg::EV_NOTE_ON],
			events_by_kind[blmp_pkg::EV_CONTROL], events_by_kind[blmp_pkg::EV_PROGRAM],
			events_by_kind[blmp_pkg::EV_BEND]);
		if (mismatches == 0) begin
			$display("ble_midi_packet_event_parser test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("ble_midi_packet_event_parser test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/blmp_pkg.sv
hw/rtl/blmp_parser.sv
hw/rtl/ble_midi_packet_event_parser.sv
test/testbench.sv
